[hw/rtl/vcs_pkg.sv]
// Shared constants, status and register codes, and sequencer states for the
// virtual clock packet scheduler. No dependencies.
`default_nettype none

package vcs_pkg;

  localparam int NUM_FLOWS   = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int FLOW_W   = 2;
  localparam int TICK_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int TAG_W    = 48;
  localparam int IVL_W    = 24;
  localparam int FRAC_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ACTIVE_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam int FIDX_W   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W    = SLOT_W + 1;
  localparam int ENTRY_W  = STAMP_W + TAG_W;
  localparam int RAM_DEPTH = NUM_FLOWS * (2 ** SLOT_W);
  localparam int ADDR_W   = FIDX_W + SLOT_W;

  localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROP_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROP_INACT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SENT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_NEXT    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_FLOWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL3    = 3'd4;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ENQ_CHECK,
    SEQ_ENQ_BASE,
    SEQ_ENQ_ADD,
    SEQ_NXT_READ,
    SEQ_NXT_CMP,
    SEQ_NXT_POP,
    SEQ_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/vcs_if.sv]
// Valid/ready channel interfaces of the scheduler: request, response and
// configuration write. Depends on vcs_pkg.
`default_nettype none

interface vcs_req_if import vcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [FLOW_W-1:0]   flow_id;
  logic [TICK_W-1:0]   now_tick;
  logic [STAMP_W-1:0]  pkt_stamp;

  modport source (output valid, op, flow_id, now_tick, pkt_stamp, input ready);
  modport sink   (input valid, op, flow_id, now_tick, pkt_stamp, output ready);
endinterface

interface vcs_rsp_if import vcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FLOW_W-1:0]   out_flow;
  logic [STAMP_W-1:0]  out_stamp;
  logic [TAG_W-1:0]    out_tag;

  modport source (output valid, status, out_flow, out_stamp, out_tag, input ready);
  modport sink   (input valid, status, out_flow, out_stamp, out_tag, output ready);
endinterface

interface vcs_cfg_if import vcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [IVL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/virtual_clock_packet_scheduler.sv]
// Virtual clock packet scheduler top level: sequencer, flow state, config
// registers and result register. Depends on vcs_pkg, vcs_if and vcs_ram.
// An enqueue word steps through the check, base, add and finish states; a
// dropped packet goes from the check state straight to finish. A next-packet
// word reads each flow head from the queue RAM in turn and compares it with
// the running minimum on the shared comparator. Reset (synchronous, rst high)
// clears flow clocks, heads, counts and active_flows and sets each interval to
// 256; the queue RAM is not cleared, since only written entries are ever used.
`default_nettype none

module virtual_clock_packet_scheduler import vcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  vcs_req_if.sink    req,
  vcs_rsp_if.source  rsp,
  vcs_cfg_if.sink    cfg
);

  // Sequencer state.
  seq_state_t state, state_next;

  // Latched request word.
  logic [FLOW_W-1:0]  flow_r;
  logic [TICK_W-1:0]  now_r;
  logic [STAMP_W-1:0] stamp_r;

  // Per-flow state and configuration.
  logic [TAG_W-1:0]    flow_clock [NUM_FLOWS];
  logic [SLOT_W-1:0]   head       [NUM_FLOWS];
  logic [CNT_W-1:0]    count      [NUM_FLOWS];
  logic [ACTIVE_W-1:0] active_flows;
  logic [IVL_W-1:0]    interval   [4];

  // Working registers of the enqueue and scan sequences.
  logic [TAG_W-1:0]   base;
  logic [FIDX_W-1:0]  scan_f;
  logic               found;
  logic [FIDX_W-1:0]  best_f;
  logic [TAG_W-1:0]   best_tag;
  logic [STAMP_W-1:0] best_stamp;

  // Pending result, then the output register toward the consumer.
  logic [STATUS_W-1:0] res_status;
  logic [FLOW_W-1:0]   res_flow;
  logic [STAMP_W-1:0]  res_stamp;
  logic [TAG_W-1:0]    res_tag;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [FLOW_W-1:0]   rsp_flow;
  logic [STAMP_W-1:0]  rsp_stamp;
  logic [TAG_W-1:0]    rsp_tag;

  // Queue RAM ports.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TAG_W-1:0]   ram_tag;
  logic [STAMP_W-1:0] ram_stamp;

  // Shared 48-bit comparator: picks the larger base on enqueue and the
  // smaller head tag during the scan.
  logic [TAG_W-1:0] unit_a;
  logic [TAG_W-1:0] unit_b;
  logic             unit_lt;

  logic                req_ready;
  logic                req_fire;
  logic                out_free;
  logic [FIDX_W-1:0]   fidx;
  logic [ACTIVE_W-1:0] limit;
  logic                inactive;
  logic                full;
  logic [TAG_W-1:0]    now_fx;
  logic [TAG_W:0]      sum;
  logic [TAG_W-1:0]    tag_new;
  logic [SUM_W-1:0]    slot_sum;
  logic [SLOT_W-1:0]   slot;
  logic                scan_last;
  logic                any_pending;

  assign req_fire = req.valid && req_ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign fidx     = flow_r[FIDX_W-1:0];

  // An active_flows value above the flow count acts as the flow count.
  assign limit    = (active_flows > ACTIVE_W'(NUM_FLOWS)) ? ACTIVE_W'(NUM_FLOWS)
                                                          : active_flows;
  assign inactive = (ACTIVE_W'(flow_r) >= limit);
  assign full     = (count[fidx] >= CNT_W'(QUEUE_DEPTH));

  assign now_fx   = {{(TAG_W - TICK_W - FRAC_W){1'b0}}, now_r, {FRAC_W{1'b0}}};

  // The tag saturates instead of wrapping when base plus interval overflows.
  assign sum      = {1'b0, base} + {{(TAG_W + 1 - IVL_W){1'b0}}, interval[flow_r]};
  assign tag_new  = sum[TAG_W] ? TAG_MAX : sum[TAG_W-1:0];

  // Tail slot is head plus count, wrapped once around the queue depth.
  assign slot_sum = SUM_W'(head[fidx]) + SUM_W'(count[fidx]);
  assign slot     = (slot_sum >= SUM_W'(QUEUE_DEPTH))
                    ? SLOT_W'(slot_sum - SUM_W'(QUEUE_DEPTH))
                    : slot_sum[SLOT_W-1:0];

  assign scan_last = (scan_f == FIDX_W'(NUM_FLOWS - 1));
  assign ram_tag   = ram_rdata[TAG_W-1:0];
  assign ram_stamp = ram_rdata[ENTRY_W-1:TAG_W];
  assign unit_lt   = (unit_a < unit_b);

  always_comb begin
    any_pending = 1'b0;
    for (int f = 0; f < NUM_FLOWS; f++) begin
      any_pending = any_pending || (count[f] != '0);
    end
  end

  vcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({stamp_r, tag_new}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (req_fire) begin
          state_next = (req.op == OP_NEXT) ? SEQ_NXT_READ : SEQ_ENQ_CHECK;
        end
      end
      SEQ_ENQ_CHECK: begin
        state_next = (inactive || full) ? SEQ_FINISH : SEQ_ENQ_BASE;
      end
      SEQ_ENQ_BASE:  state_next = SEQ_ENQ_ADD;
      SEQ_ENQ_ADD:   state_next = SEQ_FINISH;
      SEQ_NXT_READ:  state_next = SEQ_NXT_CMP;
      SEQ_NXT_CMP:   state_next = scan_last ? SEQ_NXT_POP : SEQ_NXT_READ;
      SEQ_NXT_POP:   state_next = SEQ_FINISH;
      SEQ_FINISH: begin
        if (out_free) begin
          state_next = SEQ_IDLE;
        end
      end
      default:       state_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM controls and comparator operands.
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {fidx, slot};
    ram_raddr = {scan_f, head[scan_f]};
    unit_a    = flow_clock[fidx];
    unit_b    = now_fx;
    unique case (state)
      SEQ_IDLE:    req_ready = 1'b1;
      SEQ_ENQ_ADD: ram_we    = 1'b1;
      SEQ_NXT_CMP: begin
        unit_a = ram_tag;
        unit_b = best_tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flows <= '0;
      for (int i = 0; i < 4; i++) begin
        interval[i] <= IVL_W'(256);
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_FLOWS: active_flows <= cfg.data[ACTIVE_W-1:0];
        REG_INTERVAL0:    interval[0]  <= cfg.data;
        REG_INTERVAL1:    interval[1]  <= cfg.data;
        REG_INTERVAL2:    interval[2]  <= cfg.data;
        REG_INTERVAL3:    interval[3]  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Flow clocks, heads and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NUM_FLOWS; f++) begin
        flow_clock[f] <= '0;
        head[f]       <= '0;
        count[f]      <= '0;
      end
    end else begin
      if (state == SEQ_ENQ_ADD) begin
        flow_clock[fidx] <= tag_new;
        count[fidx]      <= count[fidx] + CNT_W'(1);
      end
      if ((state == SEQ_NXT_POP) && found) begin
        head[best_f]  <= (head[best_f] == SLOT_W'(QUEUE_DEPTH - 1))
                         ? '0 : head[best_f] + SLOT_W'(1);
        count[best_f] <= count[best_f] - CNT_W'(1);
      end
    end
  end

  // Working registers and the pending result.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      flow_r  <= req.flow_id;
      now_r   <= req.now_tick;
      stamp_r <= req.pkt_stamp;
      scan_f  <= '0;
      found   <= 1'b0;
      best_f  <= '0;
    end
    unique case (state)
      SEQ_ENQ_CHECK: begin
        res_flow  <= flow_r;
        res_stamp <= '0;
        res_tag   <= '0;
        if (inactive) begin
          res_status <= ST_DROP_INACT;
        end else begin
          res_status <= ST_DROP_FULL;
        end
      end
      SEQ_ENQ_BASE: begin
        base <= unit_lt ? now_fx : flow_clock[fidx];
      end
      SEQ_ENQ_ADD: begin
        res_status <= ST_QUEUED;
        res_tag    <= tag_new;
      end
      SEQ_NXT_CMP: begin
        // Strict compare keeps the lowest flow on equal tags.
        if ((count[scan_f] != '0) && (!found || unit_lt)) begin
          found      <= 1'b1;
          best_f     <= scan_f;
          best_tag   <= ram_tag;
          best_stamp <= ram_stamp;
        end
        scan_f <= scan_f + FIDX_W'(1);
      end
      SEQ_NXT_POP: begin
        if (found) begin
          res_status <= ST_SENT;
          res_flow   <= FLOW_W'(best_f);
          res_stamp  <= best_stamp;
          res_tag    <= best_tag;
        end else begin
          res_status <= ST_NONE;
          res_flow   <= '0;
          res_stamp  <= '0;
          res_tag    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == SEQ_FINISH) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == SEQ_FINISH) && out_free) begin
      rsp_status <= res_status;
      rsp_flow   <= res_flow;
      rsp_stamp  <= res_stamp;
      rsp_tag    <= res_tag;
    end
  end

  assign req.ready     = req_ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.out_flow  = rsp_flow;
  assign rsp.out_stamp = rsp_stamp;
  assign rsp.out_tag   = rsp_tag;

  // A packet is only written into a queue that still has room.
  assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_ENQ_ADD) |-> (count[fidx] < CNT_W'(QUEUE_DEPTH)))
    else $error("enqueue into a full queue");

  // The scan finds a head exactly when some queue holds a packet.
  assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_NXT_POP) |-> (found == any_pending))
    else $error("scan result disagrees with queue counts");

  // Serving a packet removes exactly one entry from the chosen flow.
  assert property (@(posedge clk) disable iff (rst)
    ((state == SEQ_NXT_POP) && found) |=>
      (count[$past(best_f)] == $past(count[best_f]) - CNT_W'(1)))
    else $error("served flow count did not drop by one");

  // A response word appears only as the sequencer finishes an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == SEQ_FINISH))
    else $error("response raised outside the finish step");

endmodule

`default_nettype wire

[hw/rtl/vcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module vcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the virtual clock packet scheduler.
// Depends on vcs_pkg, the vcs_if channel interfaces and the scheduler RTL.
`timescale 1ns / 100ps

module testbench import vcs_pkg::*; ();

  // Random part: phases of words, each phase under its own register setting.
  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 165;
  // The response side stops taking results for a long stretch once this many
  // results have been seen, so that the scheduler backs up into its request port.
  localparam int PRESSURE_AT     = 200;
  localparam int PRESSURE_HOLD   = 300;
  // The slowest word is a next-packet request.
  localparam int DRAIN_CYCLES    = 30;
  localparam int LIMIT_NS        = 20_000_000;

  typedef struct packed {
    logic                op;
    logic [FLOW_W-1:0]   flow;
    logic [TICK_W-1:0]   now;
    logic [STAMP_W-1:0]  stamp;
  } sched_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FLOW_W-1:0]   flow;
    logic [STAMP_W-1:0]  stamp;
    logic [TAG_W-1:0]    tag;
  } sched_result_t;

  typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;

  // One row of the directed table: either a register write or a request word,
  // the latter optionally with its result typed in by hand.
  typedef struct {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [IVL_W-1:0]    value;
    sched_word_t         w;
    bit                  typed;
    sched_result_t       want;
  } stim_row_t;

  logic clk;
  logic rst;

  vcs_req_if req ();
  vcs_rsp_if rsp ();
  vcs_cfg_if cfg ();

  virtual_clock_packet_scheduler DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Scheduler model: register copies, per-flow virtual clocks and FIFOs.
  logic [ACTIVE_W-1:0] cfg_active;
  logic [IVL_W-1:0]    cfg_ivl    [NUM_FLOWS];
  logic [TAG_W-1:0]    vclk       [NUM_FLOWS];
  logic [STAMP_W-1:0]  fifo_stamp [NUM_FLOWS][QUEUE_DEPTH];
  logic [TAG_W-1:0]    fifo_tag   [NUM_FLOWS][QUEUE_DEPTH];
  logic [SLOT_W-1:0]   fifo_head  [NUM_FLOWS];
  int                  fifo_fill  [NUM_FLOWS];

  sched_result_t expected_results[$];
  int mismatches   = 0;
  int results_seen = 0;

  // Idle control shared by the request and response processes.
  bit sender_quiet   = 1'b1;
  bit receiver_quiet = 1'b1;
  // Whether valid is currently held high on the request or register channel.
  bit word_offering  = 1'b0;
  bit cfg_offering   = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Idle stretch length: mostly a few cycles, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Works out the result of one accepted word and advances the model.
  // An enqueue stamps the packet with max(flow clock, now) + interval, with
  // the sum clamped at the largest tag. A next-packet request serves the
  // smallest head tag over every flow, active or not; on a tie the lowest
  // flow number is served.
  function automatic sched_result_t schedule_word(input sched_word_t w);
    sched_result_t     r;
    int                lim;
    int                pick;
    logic [TAG_W-1:0]  now_fx;
    logic [TAG_W-1:0]  base;
    logic [TAG_W-1:0]  best;
    logic [TAG_W:0]    sum;
    logic [SLOT_W-1:0] slot;
    r = '0;
    if (w.op == OP_ENQUEUE) begin
      lim = (cfg_active > NUM_FLOWS) ? NUM_FLOWS : int'(cfg_active);
      r.flow = w.flow;
      if (int'(w.flow) >= lim) begin
        r.status = ST_DROP_INACT;
      end else if (fifo_fill[w.flow] >= QUEUE_DEPTH) begin
        r.status = ST_DROP_FULL;
      end else begin
        now_fx = '0;
        now_fx[TICK_W+FRAC_W-1:FRAC_W] = w.now;
        base = (vclk[w.flow] > now_fx) ? vclk[w.flow] : now_fx;
        sum = {1'b0, base} + cfg_ivl[w.flow];
        r.tag = (sum > {1'b0, TAG_MAX}) ? TAG_MAX : sum[TAG_W-1:0];
        r.status = ST_QUEUED;
        vclk[w.flow] = r.tag;
        slot = fifo_head[w.flow] + SLOT_W'(fifo_fill[w.flow]);
        fifo_stamp[w.flow][slot] = w.stamp;
        fifo_tag[w.flow][slot] = r.tag;
        fifo_fill[w.flow]++;
      end
    end else begin
      pick = -1;
      best = '0;
      for (int f = 0; f < NUM_FLOWS; f++) begin
        if (fifo_fill[f] != 0 && (pick < 0 || fifo_tag[f][fifo_head[f]] < best)) begin
          pick = f;
          best = fifo_tag[f][fifo_head[f]];
        end
      end
      if (pick < 0) begin
        r.status = ST_NONE;
      end else begin
        r.status = ST_SENT;
        r.flow = FLOW_W'(pick);
        r.stamp = fifo_stamp[pick][fifo_head[pick]];
        r.tag = best;
        fifo_head[pick] = fifo_head[pick] + 1'b1;
        fifo_fill[pick]--;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [IVL_W-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_REG, idx: idx, value: value, w: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t word_row(input logic op, input logic [FLOW_W-1:0] flow,
                                         input logic [TICK_W-1:0] now,
                                         input logic [STAMP_W-1:0] stamp);
    stim_row_t row;
    row = '{kind: ROW_WORD, idx: '0, value: '0, w: {op, flow, now, stamp},
            typed: 1'b0, want: '0};
    return row;
  endfunction

  // A word whose result is obvious: the returned stamp is zero in every such case.
  function automatic stim_row_t typed_row(input logic op, input logic [FLOW_W-1:0] flow,
                                          input logic [TICK_W-1:0] now,
                                          input logic [STAMP_W-1:0] stamp,
                                          input logic [STATUS_W-1:0] status,
                                          input logic [FLOW_W-1:0] out_flow,
                                          input logic [TAG_W-1:0] tag);
    stim_row_t row;
    row = word_row(op, flow, now, stamp);
    row.typed = 1'b1;
    row.want = '{status: status, flow: out_flow, stamp: '0, tag: tag};
    return row;
  endfunction

  // Offers one word, possibly after an idle gap, and books its expected
  // result at the edge where the scheduler takes it. Valid stays high after
  // the handshake so that back-to-back words never lower and raise it in one step.
  task automatic send_word(input sched_word_t w, input bit typed, input sched_result_t want);
    int gap;
    sched_result_t predicted;
    gap = (!sender_quiet && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (cfg_offering) begin
      cfg.valid <= 1'b0;
      cfg_offering = 1'b0;
    end
    if (gap > 0) begin
      if (word_offering) begin
        req.valid <= 1'b0;
        word_offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= w.op;
    req.flow_id   <= w.flow;
    req.now_tick  <= w.now;
    req.pkt_stamp <= w.stamp;
    word_offering = 1'b1;
    do @(posedge clk); while (!req.ready);
    predicted = schedule_word(w);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
  endtask

  // Register writes happen only with the scheduler idle: the request channel
  // is quiet and every booked result has come back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] value);
    if (word_offering) begin
      req.valid <= 1'b0;
      word_offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    cfg_offering = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_ACTIVE_FLOWS)
      cfg_active = value[ACTIVE_W-1:0];
    else
      cfg_ivl[FIDX_W'(idx - REG_INTERVAL0)] = value;
  endtask

  // Interval picks lean on the extremes and on small values, so that tags
  // of different flows stay close enough to compete for service.
  function automatic logic [IVL_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {IVL_W{1'b1}};
      2:       return IVL_W'(256);
      3:       return IVL_W'($urandom);
      default: return IVL_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Response side: checks each result against the oldest booked one and
  // drives ready with random stalls, plus one long hold-off for back-pressure.
  initial begin : take_results
    int hold;
    sched_result_t got;
    sched_result_t want;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.out_flow, rsp.out_stamp, rsp.out_tag};
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d flow %0d",
                                    got.status, got.flow));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, got.status, want.status));
          if (got.flow !== want.flow)
            report_mismatch($sformatf("result %0d flow %0d, expected %0d",
                                      results_seen, got.flow, want.flow));
          if (got.stamp !== want.stamp)
            report_mismatch($sformatf("result %0d stamp %h, expected %h",
                                      results_seen, got.stamp, want.stamp));
          if (got.tag !== want.tag)
            report_mismatch($sformatf("result %0d tag %h, expected %h",
                                      results_seen, got.tag, want.tag));
        end
        if (results_seen == PRESSURE_AT)
          hold = PRESSURE_HOLD;
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if (receiver_quiet || $urandom_range(0, 99) < 75) begin
        rsp.ready <= 1'b1;
      end else begin
        hold = idle_len() - 1;
        rsp.ready <= 1'b0;
      end
    end
  end

  initial begin : run_limit
    #LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t          rows[$];
    sched_word_t        w;
    int                 lim;
    int                 enq_pct;
    logic [TICK_W-1:0]  tick;

    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.op        <= OP_ENQUEUE;
    req.flow_id   <= '0;
    req.now_tick  <= '0;
    req.pkt_stamp <= '0;
    cfg.valid     <= 1'b0;
    cfg.index     <= REG_ACTIVE_FLOWS;
    cfg.data      <= '0;

    // Model state after reset: no active flow, every interval one tick.
    cfg_active = '0;
    for (int f = 0; f < NUM_FLOWS; f++) begin
      cfg_ivl[f]   = IVL_W'(256);
      vclk[f]      = '0;
      fifo_head[f] = '0;
      fifo_fill[f] = 0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Straight out of reset nothing is queued and no flow is
    // active, so a request finds nothing and every enqueue is dropped.
    rows.insert(rows.size(), typed_row(OP_NEXT, 2'd0, '0, '0, ST_NONE, 2'd0, '0));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd3, '1, '1, ST_DROP_INACT, 2'd3, '0));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd0, '0, '0, ST_DROP_INACT, 2'd0, '0));
    // A flow count above the number of flows acts as all flows. Intervals at
    // zero, at the top of their range, at one tick and at one fraction step.
    rows.insert(rows.size(), reg_row(REG_ACTIVE_FLOWS, IVL_W'(7)));
    rows.insert(rows.size(), reg_row(REG_INTERVAL0, '0));
    rows.insert(rows.size(), reg_row(REG_INTERVAL1, '1));
    rows.insert(rows.size(), reg_row(REG_INTERVAL2, IVL_W'(256)));
    rows.insert(rows.size(), reg_row(REG_INTERVAL3, IVL_W'(1)));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd0, '0, '0, ST_QUEUED, 2'd0, '0));
    rows.insert(rows.size(), word_row(OP_ENQUEUE, 2'd1, '1, '1));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd2, '0, 32'h5A5A_5A5A, ST_QUEUED,
                                       2'd2, TAG_W'(256)));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd3, '0, 32'hA5A5_A5A5, ST_QUEUED,
                                       2'd3, TAG_W'(1)));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd0, '0, 32'd1, ST_QUEUED, 2'd0, '0));
    // Serve everything in tag order, then ask once more with all queues empty.
    repeat (5) rows.insert(rows.size(), word_row(OP_NEXT, '1, '1, '1));
    rows.insert(rows.size(), typed_row(OP_NEXT, 2'd0, '0, '0, ST_NONE, 2'd0, '0));
    // Flows 0 and 2 end up with equal tags; the lower flow goes first.
    rows.insert(rows.size(), word_row(OP_ENQUEUE, 2'd2, 32'd5, 32'd2));
    rows.insert(rows.size(), word_row(OP_ENQUEUE, 2'd0, 32'd6, 32'd3));
    rows.insert(rows.size(), word_row(OP_NEXT, 2'd0, '0, '0));
    // Shrink to one flow: flow 2 now drops new packets, yet its queued one is
    // still served. Flow 0 keeps its clock, which is ahead of the new tick.
    rows.insert(rows.size(), reg_row(REG_ACTIVE_FLOWS, IVL_W'(1)));
    rows.insert(rows.size(), typed_row(OP_ENQUEUE, 2'd2, '0, '0, ST_DROP_INACT, 2'd2, '0));
    rows.insert(rows.size(), word_row(OP_NEXT, 2'd0, '0, '0));
    rows.insert(rows.size(), word_row(OP_ENQUEUE, 2'd0, '0, 32'd7));
    rows.insert(rows.size(), word_row(OP_NEXT, 2'd0, '0, '0));
    rows.insert(rows.size(), typed_row(OP_NEXT, 2'd0, '0, '0, ST_NONE, 2'd0, '0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG)
        write_reg(rows[i].idx, rows[i].value);
      else
        send_word(rows[i].w, rows[i].typed, rows[i].want);
    end

    // Random phases. The first runs with no idling at all; the second keeps
    // the request side busy while the response side holds off, so the
    // scheduler fills up. Enqueue-heavy phases drive queues to full, light
    // ones drain them; one phase starts its tick count just short of wrapping.
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_quiet   = (p <= 1);
      receiver_quiet = (p == 0);
      write_reg(REG_ACTIVE_FLOWS, (p == 0) ? IVL_W'(NUM_FLOWS) : IVL_W'($urandom_range(0, 7)));
      for (int k = 0; k < NUM_FLOWS; k++)
        write_reg(CFG_IDX_W'(REG_INTERVAL0 + k), pick_interval());
      lim = (cfg_active > NUM_FLOWS) ? NUM_FLOWS : int'(cfg_active);
      case (p % 4)
        0:       enq_pct = 55;
        1:       enq_pct = 85;
        2:       enq_pct = 30;
        default: enq_pct = 70;
      endcase
      tick = (p == 3) ? 32'hFFFF_FF00 : $urandom;
      repeat (WORDS_PER_PHASE) begin
        // Most packets go to active flows and carry a slowly advancing tick;
        // a few hit any flow or jump to an arbitrary time.
        tick = tick + $urandom_range(0, 3);
        w.op    = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_NEXT;
        w.flow  = (lim > 0 && $urandom_range(0, 9) != 0) ? FLOW_W'($urandom_range(0, lim - 1))
                                                         : FLOW_W'($urandom_range(0, 3));
        w.now   = ($urandom_range(0, 19) == 0) ? $urandom : tick;
        w.stamp = $urandom;
        send_word(w, 1'b0, '0);
      end
    end

    // Let the last results come back, then allow a few more cycles for
    // anything the scheduler should not have produced.
    req.valid <= 1'b0;
    word_offering = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
